// File: sv/ede_pkg.sv
// ----------------------------------------------------------------------------
// ede_pkg
// Shared types and constants for the edit distance engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ede_pkg;

  // Default longest query and name, in characters
  localparam int unsigned MAX_LEN_DEFAULT = 64;

  // Width of one character word
  localparam int unsigned SYM_W = 8;

  // Width of the reported distance
  localparam int unsigned DIST_W = 7;

  // Command codes carried on the cmd port
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_NAME   = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ROW  = 3'b010,
    ST_REP  = 3'b100
  } state_t;

endpackage

`default_nettype wire

// File: sv/ede_ram.sv
// ----------------------------------------------------------------------------
// ede_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ede_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/ede_cell.sv
// ----------------------------------------------------------------------------
// ede_cell
// One dynamic-programming cell: least of substitution, insertion and deletion.
// ----------------------------------------------------------------------------
`default_nettype none

module ede_cell #(
  parameter int unsigned CW = 7
) (
  input  wire logic [CW-1:0] diag,
  input  wire logic [CW-1:0] left,
  input  wire logic [CW-1:0] up,
  input  wire logic          match,
  output logic      [CW-1:0] cost
);

  logic [CW-1:0] sub_cost;
  logic [CW-1:0] ins_cost;
  logic [CW-1:0] del_cost;
  logic [CW-1:0] min_ab;

  // Substitution is free on a matching character
  assign sub_cost = diag + CW'(!match);
  assign ins_cost = left + CW'(1);
  assign del_cost = up + CW'(1);

  // Take the least of the three
  assign min_ab = (ins_cost < sub_cost) ? ins_cost : sub_cost;
  assign cost   = (del_cost < min_ab) ? del_cost : min_ab;

endmodule

`default_nettype wire

// File: sv/edit_distance_engine_unit.sv
// ----------------------------------------------------------------------------
// edit_distance_engine_unit
// Levenshtein distance between a stored query and a name streamed one
// character at a time.
// ----------------------------------------------------------------------------
// Issue a word by raising start with cmd and symbol while busy is low. Clear
// and append never raise busy, nor does a name character against an empty query.
// A name character with a non-empty query of length L keeps busy high until
// the row walk has written back all L cells: the cost row lives in a RAM with
// one read and one write port, and the row walk reads, updates and writes back
// one cell per cycle. End of name passes through the report state, from which
// the result is registered onto distance and truncated and shown for a single
// cycle with valid high.
// The receiver cannot stall, so it must capture the result on that cycle.
// No clearing pass follows reset; the block takes words straight away.
// ----------------------------------------------------------------------------
`default_nettype none

module edit_distance_engine_unit #(
  parameter int unsigned MAX_LEN = ede_pkg::MAX_LEN_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   cmd,
  input  wire logic [ede_pkg::SYM_W-1:0]    symbol,
  output logic                              valid,
  output logic      [ede_pkg::DIST_W-1:0]   distance,
  output logic                              truncated
);

  // Length counters and row indexes hold 0..MAX_LEN
  localparam int unsigned LW  = $clog2(MAX_LEN + 1);
  // Costs reach MAX_LEN + 1 inside a cell
  localparam int unsigned CW  = $clog2(MAX_LEN + 2);
  // Query store address
  localparam int unsigned QAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned DW  = ede_pkg::DIST_W;
  localparam int unsigned SW  = ede_pkg::SYM_W;
  localparam logic [LW-1:0] MAXL = LW'(MAX_LEN);

  ede_pkg::state_t state;
  ede_pkg::cmd_t   cmd_in;

  logic          accept;
  logic [LW-1:0] qlen;
  logic [LW-1:0] nlen;
  logic          ovf;
  logic          fresh;
  logic [LW-1:0] rd_idx;
  logic          rd_active;
  logic          cmp_active;
  logic [LW-1:0] cmp_idx;

  logic [CW-1:0] diag;
  logic [CW-1:0] left;
  logic [SW-1:0] sym_q;

  logic          q_we;
  logic [QAW-1:0] q_waddr;
  logic [QAW-1:0] q_raddr;
  logic [LW-1:0] q_ridx;
  logic [SW-1:0] q_rdata;

  logic          r_we;
  logic [LW-1:0] r_raddr;
  logic [CW-1:0] r_rdata;

  logic [CW-1:0] up;
  logic [CW-1:0] cost;
  logic [CW-1:0] rep_val;
  logic [CW+DW-1:0] rep_wide;

  assign cmd_in = ede_pkg::cmd_t'(cmd);
  assign busy   = (state != ede_pkg::ST_IDLE);
  assign accept = start && !busy;

  // Query store: written on append, read one column ahead of the row update
  assign q_we    = accept && (cmd_in == ede_pkg::CMD_APPEND) && (qlen != MAXL);
  assign q_waddr = qlen[QAW-1:0];
  assign q_ridx  = rd_idx - LW'(1);
  assign q_raddr = q_ridx[QAW-1:0];

  ede_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_LEN)
  ) u_query_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (symbol),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // Cost row: walk reads column j while column j-1 is written back;
  // when idle, point at the query length for the end-of-name report
  assign r_we    = (state == ede_pkg::ST_ROW) && cmp_active;
  assign r_raddr = (state == ede_pkg::ST_ROW) ? rd_idx : qlen;

  ede_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_LEN + 1)
  ) u_row_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (cmp_idx),
    .wdata (cost),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  // A row not yet touched since the last re-initialisation reads as identity
  assign up = fresh ? CW'(cmp_idx) : r_rdata;

  ede_cell #(
    .CW (CW)
  ) u_cell (
    .diag  (diag),
    .left  (left),
    .up    (up),
    .match (q_rdata == sym_q),
    .cost  (cost)
  );

  // Distance at the query length, masked to the port width
  always_comb begin
    if (qlen == '0) begin
      rep_val = CW'(nlen);
    end else if (fresh) begin
      rep_val = CW'(qlen);
    end else begin
      rep_val = r_rdata;
    end
  end
  assign rep_wide = (CW + DW)'(rep_val);

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ede_pkg::ST_IDLE;
      qlen       <= '0;
      nlen       <= '0;
      ovf        <= 1'b0;
      fresh      <= 1'b1;
      rd_idx     <= '0;
      rd_active  <= 1'b0;
      cmp_active <= 1'b0;
      valid      <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        ede_pkg::ST_IDLE: begin
          if (accept) begin
            unique case (cmd_in)
              ede_pkg::CMD_CLEAR: begin
                qlen  <= '0;
                ovf   <= 1'b0;
                fresh <= 1'b1;
                nlen  <= '0;
              end
              ede_pkg::CMD_APPEND: begin
                if (qlen == MAXL) begin
                  ovf <= 1'b1;
                end else begin
                  qlen <= qlen + LW'(1);
                end
                fresh <= 1'b1;
                nlen  <= '0;
              end
              ede_pkg::CMD_NAME: begin
                if (nlen == MAXL) begin
                  ovf <= 1'b1;
                end else begin
                  nlen <= nlen + LW'(1);
                  if (qlen != '0) begin
                    state     <= ede_pkg::ST_ROW;
                    rd_idx    <= LW'(1);
                    rd_active <= 1'b1;
                  end
                end
              end
              ede_pkg::CMD_END: begin
                state <= ede_pkg::ST_REP;
              end
              default: begin
                state <= ede_pkg::ST_IDLE;
              end
            endcase
          end
        end
        ede_pkg::ST_ROW: begin
          // Advance the read column until the query length is reached
          if (rd_active) begin
            if (rd_idx == qlen) begin
              rd_active <= 1'b0;
            end else begin
              rd_idx <= rd_idx + LW'(1);
            end
          end
          cmp_active <= rd_active;
          // Finish once the last column is written back
          if (cmp_active && (cmp_idx == qlen)) begin
            state <= ede_pkg::ST_IDLE;
            fresh <= 1'b0;
          end
        end
        ede_pkg::ST_REP: begin
          valid <= 1'b1;
          nlen  <= '0;
          fresh <= 1'b1;
          state <= ede_pkg::ST_IDLE;
        end
        default: begin
          state <= ede_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Row walk data path and result registers
  always_ff @(posedge clk) begin
    if (accept && (cmd_in == ede_pkg::CMD_NAME)) begin
      diag  <= CW'(nlen);
      left  <= CW'(nlen) + CW'(1);
      sym_q <= symbol;
    end
    if (state == ede_pkg::ST_ROW) begin
      cmp_idx <= rd_idx;
      if (cmp_active) begin
        left <= cost;
        diag <= up;
      end
    end
    if (state == ede_pkg::ST_REP) begin
      distance  <= rep_wide[DW-1:0];
      truncated <= ovf;
    end
  end

endmodule

`default_nettype wire

// File: sv/ede_checker.sv
// ----------------------------------------------------------------------------
// ede_checker
// Port-level checks on the edit distance engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ede_checker #(
  parameter int unsigned MAX_LEN = ede_pkg::MAX_LEN_DEFAULT
) (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [1:0]                 cmd,
  input wire logic                       valid,
  input wire logic [ede_pkg::DIST_W-1:0] distance
);

  logic end_word;

  assign end_word = start && !busy && (cmd == ede_pkg::CMD_END);

  // Every end-of-name word yields a result with valid high
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    end_word |=> ##1 valid)
    else $error("end-of-name word without result");

  // No result without an earlier end-of-name word
  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(end_word, 2))
    else $error("result without end-of-name word");

  // Hold off the next word while the report is formed
  a_busy_after_end: assert property (@(posedge clk) disable iff (rst)
    end_word |=> busy)
    else $error("word taken while report pending");

  // Distance never exceeds the longest string
  a_distance_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> ((MAX_LEN > 127) || (distance <= MAX_LEN)))
    else $error("distance out of range");

  // Come out of reset idle and quiet
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !valid))
    else $error("not idle after reset");

endmodule

bind edit_distance_engine_unit ede_checker #(.MAX_LEN(MAX_LEN)) u_ede_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .cmd      (cmd),
  .valid    (valid),
  .distance (distance)
);

`default_nettype wire
